>>> hw/rtl/aqsd_pkg.sv
// ----------------------------------------------------------------------------
// aqsd_pkg
// Types and character constants for the AT command quoted string decoder.
// ----------------------------------------------------------------------------
package aqsd_pkg;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       field_start;
    logic       line_end;
  } in_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       field_done;
    logic       field_status;
    logic [8:0] decoded_count;
    logic       byte_consumed;
  } out_t;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_QUOTE = 3'd1;
  localparam logic [2:0] PH_ESC1  = 3'd2;
  localparam logic [2:0] PH_ESC2  = 3'd3;
  localparam logic [2:0] PH_AFTER = 3'd4;

  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;

  localparam logic [7:0] MAX_LEN_RESET = 8'd16;
  localparam logic [8:0] COUNT_SAT     = 9'd256;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t       h;
    logic [7:0] d;
    h = '0;
    d = '0;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
      h.ok = 1'b1;
    end else if (c >= CH_LC_A && c <= CH_LC_F) begin
      d = c - CH_LC_A + 8'd10;
      h.ok = 1'b1;
    end else if (c >= CH_UC_A && c <= CH_UC_F) begin
      d = c - CH_UC_A + 8'd10;
      h.ok = 1'b1;
    end
    h.value = d[3:0];
    return h;
  endfunction

endpackage

>>> hw/rtl/at_quoted_string_decoder.sv
// ----------------------------------------------------------------------------
// at_quoted_string_decoder
// Streaming decoder for one quoted string parameter of an AT command line.
//
//   Channel   Signals                          Transfer when
//   input     in_valid, in_ready, in_data      in_valid && in_ready
//   result    out_valid, out_ready, out_data   out_valid && out_ready
//   config    cfg_we, cfg_wdata                cfg_we
//
// One byte is taken per cycle; its result appears in the output register on
// the following cycle. The output register is the only pipeline stage, so
// input is held off only while a result waits and out_ready is low.
// Reset restores the idle phase, a zero count and a limit of 16 bytes.
// ----------------------------------------------------------------------------
module at_quoted_string_decoder
  import aqsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic [7:0] max_string_length;
  logic       step;
  out_t       result;

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_string_length <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_string_length <= cfg_wdata;
    end
  end

  aqsd_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_data),
    .limit  (max_string_length),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

`ifndef SYNTH
  a_data_not_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.data_valid && out_data.field_done))
    else $error("A decoded byte was reported together with field completion.");

  a_status_with_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.field_status) |-> out_data.field_done)
    else $error("Error status reported without field completion.");

  a_data_consumed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.data_valid) |-> out_data.byte_consumed)
    else $error("A decoded byte came from a byte that was not consumed.");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.data_valid) |-> (out_data.data_byte == 8'd0))
    else $error("Data byte is not zero while no byte is delivered.");

  a_start_count: assert property (@(posedge clk) disable iff (rst)
    (step && in_data.field_start) |=> (out_data.decoded_count == 9'd0))
    else $error("Count not cleared on the first byte of a field.");
`endif

endmodule

>>> hw/rtl/aqsd_decode.sv
// ----------------------------------------------------------------------------
// aqsd_decode
// Phase machine, escape nibble and byte count; forms the result of one byte.
// ----------------------------------------------------------------------------
module aqsd_decode
  import aqsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  in_t        item,
  input  logic [7:0] limit,
  output out_t       result
);

  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [3:0] high_nibble;
  logic [3:0] high_nibble_next;
  logic [8:0] byte_count;
  logic [8:0] byte_count_next;

  hex_t       hex;
  logic       emit;
  logic [7:0] emit_byte;
  logic [8:0] count_inc;

  always_comb begin
    hex              = hex_digit(item.char_byte);
    count_inc        = (byte_count < COUNT_SAT) ? byte_count + 9'd1 : byte_count;
    phase_next       = phase;
    high_nibble_next = high_nibble;
    byte_count_next  = byte_count;
    emit             = 1'b0;
    emit_byte        = '0;
    result           = '0;

    if (item.field_start) begin
      byte_count_next  = '0;
      high_nibble_next = '0;
      phase_next       = PH_IDLE;
      result.field_done = 1'b1;
      if (item.line_end) begin
        result.field_done = 1'b1;
      end else if (item.char_byte == CH_COMMA) begin
        result.byte_consumed = 1'b1;
      end else if (item.char_byte == CH_SEMI) begin
        result.field_done = 1'b1;
      end else if (item.char_byte == CH_DQUOTE) begin
        result.byte_consumed = 1'b1;
        result.field_done    = 1'b0;
        phase_next           = PH_QUOTE;
      end else begin
        result.field_status = 1'b1;
      end
    end else begin
      unique case (phase) inside
        PH_QUOTE, PH_ESC1, PH_ESC2: begin
          if (item.line_end) begin
            result.field_done   = 1'b1;
            result.field_status = 1'b1;
            phase_next          = PH_IDLE;
          end else begin
            result.byte_consumed = 1'b1;
            if (phase == PH_QUOTE) begin
              if (item.char_byte == CH_DQUOTE) begin
                result.field_done = 1'b1;
                phase_next        = PH_AFTER;
              end else if (item.char_byte == CH_BSLASH) begin
                phase_next = PH_ESC1;
              end else begin
                emit      = 1'b1;
                emit_byte = item.char_byte;
              end
            end else if (phase == PH_ESC1) begin
              if (hex.ok) begin
                high_nibble_next = hex.value;
                phase_next       = PH_ESC2;
              end else begin
                result.field_done   = 1'b1;
                result.field_status = 1'b1;
                phase_next          = PH_IDLE;
              end
            end else begin
              if (hex.ok) begin
                emit      = 1'b1;
                emit_byte = {high_nibble, hex.value};
              end else begin
                result.field_done   = 1'b1;
                result.field_status = 1'b1;
                phase_next          = PH_IDLE;
              end
            end
            if (emit) begin
              byte_count_next = count_inc;
              if (count_inc > {1'b0, limit}) begin
                result.field_done   = 1'b1;
                result.field_status = 1'b1;
                phase_next          = PH_IDLE;
              end else begin
                result.data_valid = 1'b1;
                result.data_byte  = emit_byte;
                phase_next        = PH_QUOTE;
              end
            end
          end
        end
        PH_AFTER: begin
          result.byte_consumed = !item.line_end && (item.char_byte == CH_COMMA);
          phase_next           = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    result.decoded_count = byte_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      high_nibble <= '0;
      byte_count  <= '0;
    end else if (step) begin
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
      byte_count  <= byte_count_next;
    end
  end

`ifndef SYNTH
  a_phase_legal: assert property (@(posedge clk) disable iff (rst)
    step |=> (phase == PH_IDLE || phase == PH_QUOTE || phase == PH_ESC1 ||
              phase == PH_ESC2 || phase == PH_AFTER))
    else $error("Decoder phase left the defined codes.");
`endif

endmodule
